// ----- sv/morse_light_pulse_decoder_defines.svh -----
// assertion macros for the morse light pulse decoder rtl
`ifndef MORSE_LIGHT_PULSE_DECODER_DEFINES_SVH
`define MORSE_LIGHT_PULSE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// ante implies cons in the same cycle
`define MLPD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define MLPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MLPD_ASSERT_IMPL(label, ante, cons, msg)

`define MLPD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- sv/mlpd_pkg.sv -----
// types, codes and the morse tree rom of the light pulse decoder
package mlpd_pkg;

    localparam int THRESH_W   = 10;
    localparam int DOT_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int POS_W      = 7;
    localparam int CHAR_W     = 7;
    localparam int KIND_W     = 2;

    localparam logic [POS_W:0] TREE_SIZE = 8'd127;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd10;
    localparam logic [DOT_W-1:0]    DOT_RESET    = 14'd400;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DOT    = 2'd1;

    // result event codes
    localparam logic [KIND_W-1:0] EV_DOT  = 2'd0;
    localparam logic [KIND_W-1:0] EV_DASH = 2'd1;
    localparam logic [KIND_W-1:0] EV_CHAR = 2'd2;

    typedef struct packed {
        logic [THRESH_W-1:0] light_threshold;
        logic [DOT_W-1:0]    dot_ticks;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] code;
    } result_t;

    // morse binary tree: left child 2p+1 is a dot, right child 2p+2 a dash
    function automatic logic [CHAR_W-1:0] tree_char(input logic [POS_W-1:0] pos);
        logic [CHAR_W-1:0] ch;
        case (pos)
            7'd1:    ch = 7'd69;  // E
            7'd2:    ch = 7'd84;  // T
            7'd3:    ch = 7'd73;  // I
            7'd4:    ch = 7'd65;  // A
            7'd5:    ch = 7'd78;  // N
            7'd6:    ch = 7'd77;  // M
            7'd7:    ch = 7'd83;  // S
            7'd8:    ch = 7'd85;  // U
            7'd9:    ch = 7'd82;  // R
            7'd10:   ch = 7'd87;  // W
            7'd11:   ch = 7'd68;  // D
            7'd12:   ch = 7'd75;  // K
            7'd13:   ch = 7'd71;  // G
            7'd14:   ch = 7'd79;  // O
            7'd15:   ch = 7'd72;  // H
            7'd16:   ch = 7'd86;  // V
            7'd17:   ch = 7'd70;  // F
            7'd19:   ch = 7'd76;  // L
            7'd21:   ch = 7'd80;  // P
            7'd22:   ch = 7'd74;  // J
            7'd23:   ch = 7'd66;  // B
            7'd24:   ch = 7'd88;  // X
            7'd25:   ch = 7'd67;  // C
            7'd26:   ch = 7'd89;  // Y
            7'd27:   ch = 7'd90;  // Z
            7'd28:   ch = 7'd81;  // Q
            7'd31:   ch = 7'd53;  // 5
            7'd32:   ch = 7'd52;  // 4
            7'd34:   ch = 7'd51;  // 3
            7'd38:   ch = 7'd50;  // 2
            7'd41:   ch = 7'd43;  // +
            7'd46:   ch = 7'd49;  // 1
            7'd47:   ch = 7'd54;  // 6
            7'd48:   ch = 7'd61;  // =
            7'd49:   ch = 7'd47;  // /
            7'd53:   ch = 7'd40;  // (
            7'd55:   ch = 7'd55;  // 7
            7'd59:   ch = 7'd56;  // 8
            7'd61:   ch = 7'd57;  // 9
            7'd62:   ch = 7'd48;  // 0
            7'd75:   ch = 7'd63;  // ?
            7'd76:   ch = 7'd95;  // _
            7'd81:   ch = 7'd34;  // double quote
            7'd84:   ch = 7'd46;  // .
            7'd89:   ch = 7'd64;  // @
            7'd96:   ch = 7'd45;  // -
            7'd105:  ch = 7'd59;  // ;
            7'd106:  ch = 7'd33;  // !
            7'd108:  ch = 7'd41;  // )
            7'd114:  ch = 7'd44;  // ,
            7'd119:  ch = 7'd58;  // :
            default: ch = 7'd0;   // empty nodes, including the two duplicate slots
        endcase
        return ch;
    endfunction

endpackage

// ----- sv/mlpd_cfg_regs.sv -----
// configuration registers of the light pulse decoder
module mlpd_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [mlpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mlpd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             cfg_ready,
    output mlpd_pkg::cfg_t                   cfg
);
    import mlpd_pkg::*;

    logic [THRESH_W-1:0] thresh_reg;
    logic [DOT_W-1:0]    dot_reg;
    logic [THRESH_W-1:0] thresh_next;
    logic [DOT_W-1:0]    dot_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        thresh_next = thresh_reg;
        dot_next    = dot_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IDX_THRESH: thresh_next = cfg_data[THRESH_W-1:0];
                CFG_IDX_DOT:    dot_next    = cfg_data[DOT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            dot_reg    <= DOT_RESET;
        end
        else
        begin
            thresh_reg <= thresh_next;
            dot_reg    <= dot_next;
        end
    end

    assign cfg.light_threshold = thresh_reg;
    assign cfg.dot_ticks       = dot_reg;

endmodule

// ----- sv/mlpd_decoder.sv -----
// run counters, morse tree walk and event decision for one sample
module mlpd_decoder #(
    parameter int COUNT_WIDTH  = 16,
    parameter int SAMPLE_WIDTH = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  mlpd_pkg::cfg_t          cfg,
    output mlpd_pkg::result_t       result
);
    import mlpd_pkg::*;

    localparam int CMP_W = (SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W;

    logic [COUNT_WIDTH-1:0] on_run_reg, on_run_next;
    logic [COUNT_WIDTH-1:0] off_run_reg, off_run_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   ovf_reg, ovf_next;

    logic [COUNT_WIDTH-1:0] dot_len;
    logic [COUNT_WIDTH-1:0] two_dot;
    logic [COUNT_WIDTH-1:0] on_inc;
    logic [COUNT_WIDTH-1:0] off_inc;
    logic                   light_on;
    logic                   is_dot;
    logic                   is_dash;
    logic [POS_W:0]         child;

    assign dot_len  = COUNT_WIDTH'(cfg.dot_ticks);
    assign two_dot  = COUNT_WIDTH'({cfg.dot_ticks, 1'b0});
    assign light_on = CMP_W'(sample) <= CMP_W'(cfg.light_threshold);

    // saturating counts
    assign on_inc  = (&on_run_reg)  ? on_run_reg  : on_run_reg + 1'b1;
    assign off_inc = (&off_run_reg) ? off_run_reg : off_run_reg + 1'b1;

    assign is_dash = on_run_reg >= two_dot;
    assign is_dot  = (on_run_reg >= dot_len) && !is_dash;

    // dash child is 2p+2, dot child 2p+1
    assign child = is_dash ? ({pos_reg, 1'b0} + (POS_W+1)'(2)) : {pos_reg, 1'b1};

    always_comb
    begin
        on_run_next  = on_run_reg;
        off_run_next = off_run_reg;
        pos_next     = pos_reg;
        ovf_next     = ovf_reg;
        result       = '0;
        if (step)
        begin
            if (light_on)
            begin
                on_run_next  = on_inc;
                off_run_next = '0;
            end
            else
            begin
                on_run_next  = '0;
                off_run_next = off_inc;
                if (is_dot || is_dash)
                begin
                    result.valid = 1'b1;
                    result.kind  = is_dash ? EV_DASH : EV_DOT;
                    if (!ovf_reg)
                    begin
                        if (child >= TREE_SIZE)
                            ovf_next = 1'b1;
                        else
                            pos_next = child[POS_W-1:0];
                    end
                end
                else if ((off_inc == two_dot) && ((pos_reg != '0) || ovf_reg))
                begin
                    result.valid = 1'b1;
                    result.kind  = EV_CHAR;
                    result.code  = ovf_reg ? '0 : tree_char(pos_reg);
                    pos_next     = '0;
                    ovf_next     = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_run_reg  <= '0;
            off_run_reg <= '0;
            pos_reg     <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            on_run_reg  <= on_run_next;
            off_run_reg <= off_run_next;
            pos_reg     <= pos_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

// ----- sv/morse_light_pulse_decoder.sv -----
// top level of the morse light pulse decoder
//
// input channel: one light sample per request on light_sample, taken at an
// edge with in_valid high and in_stall low. a sample at or below the light
// threshold counts as light on
// output channel: event_kind / char_code with out_valid, taken at an edge
// with out_stall low. dot and dash events carry char_code 0, a character
// event carries the ascii code (0 for an empty tree node or on overflow)
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
// index 0 is the light threshold, index 1 the dot length in samples.
// cfg_ready is always high, writes are meant for an idle block
// a sample that causes an event reaches out_valid via the input register,
// then the result register. throughput: one sample per cycle unless
// out_stall blocks a waiting result, set by the single pass from the input
// register through the counters and tree step into the result register
// most samples cause no event and leave the output untouched
// reset: counters, tree position and overflow clear, registers take their
// defaults (threshold 10, dot length 400), both pipeline stages empty
// stall: a waiting result holds; the input register still takes one more
// sample, then in_stall rises until the result is taken
module morse_light_pulse_decoder #(
    parameter int COUNT_WIDTH  = 16,
    parameter int SAMPLE_WIDTH = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [SAMPLE_WIDTH-1:0]          light_sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mlpd_pkg::KIND_W-1:0]      event_kind,
    output logic [mlpd_pkg::CHAR_W-1:0]      char_code,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mlpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mlpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mlpd_pkg::*;

    `include "morse_light_pulse_decoder_defines.svh"

    cfg_t    cfg;
    result_t result;

    // input register
    logic                    s1_valid_reg, s1_valid_next;
    logic [SAMPLE_WIDTH-1:0] s1_sample_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg;
    logic [CHAR_W-1:0] out_code_reg;

    logic out_blocked;
    logic s1_fire;
    logic in_fire;
    logic res_load;

    mlpd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    mlpd_decoder #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dec (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_fire),
        .sample (s1_sample_reg),
        .cfg    (cfg),
        .result (result)
    );

    // a waiting result that is not taken blocks the decode step
    assign out_blocked = out_valid_reg && out_stall;
    assign s1_fire     = s1_valid_reg && !out_blocked;
    assign in_stall    = s1_valid_reg && out_blocked;
    assign in_fire     = in_valid && !in_stall;
    assign res_load    = s1_fire && result.valid;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        // an unblocked result register is either refilled or emptied
        out_valid_next = out_valid_reg;
        if (!out_blocked)
            out_valid_next = res_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_sample_reg <= light_sample;
        if (res_load)
        begin
            out_kind_reg <= result.kind;
            out_code_reg <= result.code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign char_code  = out_code_reg;

    `MLPD_ASSERT_IMPL(a_stall_only_when_blocked, in_stall, s1_valid_reg && out_blocked, "bad stall")
    `MLPD_ASSERT_IMPL(a_code_only_on_char, out_valid_reg && (out_kind_reg != EV_CHAR), out_code_reg == '0, "bad code")
    `MLPD_ASSERT_NEXT(a_result_loaded, res_load, out_valid_reg, "decoded event lost")

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the morse light pulse decoder
`timescale 1ns / 100ps

module tb_top;
    import mlpd_pkg::*;

    // timing and run shape
    localparam int  IDLE_PCT       = 14;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  PHASE_SAMPLES  = 120;
    localparam int  RANDOM_PHASES  = 5;
    localparam int  SETTLE_CYCLES  = 6;
    localparam int  DRAIN_GUARD    = 20000;
    localparam int  MAX_REPORTS    = 10;
    localparam real RUN_LIMIT_NS   = 40_000_000.0;

    localparam int              TREE_NODES     = 127;
    localparam int              SAMPLE_MAX     = 1023;
    localparam logic [15:0]     RUN_MAX        = 16'hFFFF;
    // index that maps to no register, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] code;
    } morse_event_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic [9:0]             light_sample = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic [KIND_W-1:0]      event_kind;
    logic [CHAR_W-1:0]      char_code;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    morse_light_pulse_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .light_sample (light_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .char_code    (char_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // samples waiting for the driver, and decoder events still to come out
    logic [9:0]     sample_q[$];
    morse_event_t   pending_events[$];

    // shared flags between stimulus, driver and receiver
    bit  sample_accepted = 1'b0;   // request taken at the last rising edge
    bit  calm            = 1'b0;   // no idling on either side
    bit  hold_off        = 1'b0;   // receiver holds off for a long stretch
    bit  squeeze_go      = 1'b0;

    int  fault_count     = 0;
    int  samples_taken   = 0;
    int  queued_items    = 0;
    int  reg_writes      = 0;
    int  dots_checked    = 0;
    int  dashes_checked  = 0;
    int  chars_checked   = 0;

    // stimulus-side view of the current register settings
    int  cur_thr = THRESH_RESET;
    int  cur_dot = DOT_RESET;

    // ------------------------------------------------------------------
    // behavioral decoder: own copy of registers, run counters and tree walk
    // ------------------------------------------------------------------
    logic [9:0]        track_thr;
    logic [13:0]       track_dot;
    logic [15:0]       track_on_run;
    logic [15:0]       track_off_run;
    logic [6:0]        track_pos;
    logic              track_ovf;
    logic [CHAR_W-1:0] tree_ascii [0:TREE_NODES-1];

    // morse tree laid out breadth first, '*' marks a node with no character
    // (the two duplicate slots under U and R are empty on purpose)
    initial
    begin
        string rows [0:15];
        rows = '{"*ETIANMS", "URWDKGOH", "VF*L*PJB", "XCYZQ**5",
                 "4*3***2*", "*+****16", "=/***(*7", "***8*90*",
                 "********", "***?_***", "*\"**.***", "*@******",
                 "-*******", "*;!*)***", "**,****:", "*******"};
        for (int r = 0; r < 16; r++)
        begin
            for (int k = 0; k < rows[r].len(); k++)
            begin
                if (rows[r][k] == "*")
                    tree_ascii[8*r+k] = '0;
                else
                    tree_ascii[8*r+k] = CHAR_W'(rows[r][k]);
            end
        end
    end

    // a dot goes to the left child, a dash to the right; past the last
    // node the walk freezes and only the overflow flag remembers it
    task automatic climb_tree(input int step);
        int nxt;
        if (track_ovf)
            return;
        nxt = 2 * int'(track_pos) + step;
        if (nxt >= TREE_NODES)
            track_ovf = 1'b1;
        else
            track_pos = nxt[6:0];
    endtask

    task automatic decode_sample(input logic [9:0] s);
        int           dot_len;
        int           two_dot;
        morse_event_t ev;
        dot_len = int'(track_dot);
        two_dot = 2 * dot_len;
        if (s <= track_thr)
        begin
            // light on: extend the on run, the off run starts over
            if (track_on_run != RUN_MAX)
                track_on_run++;
            track_off_run = '0;
            return;
        end
        if (track_off_run != RUN_MAX)
            track_off_run++;
        if (int'(track_on_run) >= dot_len && int'(track_on_run) < two_dot)
        begin
            climb_tree(1);
            ev.kind = EV_DOT;
            ev.code = '0;
            pending_events.push_back(ev);
        end
        else if (int'(track_on_run) >= two_dot)
        begin
            climb_tree(2);
            ev.kind = EV_DASH;
            ev.code = '0;
            pending_events.push_back(ev);
        end
        else if (int'(track_off_run) == two_dot && (track_pos != 0 || track_ovf))
        begin
            // gap long enough: character out, walk back to the root
            ev.kind = EV_CHAR;
            ev.code = track_ovf ? '0 : tree_ascii[track_pos];
            pending_events.push_back(ev);
            track_pos = '0;
            track_ovf = 1'b0;
        end
        track_on_run = '0;
    endtask

    task automatic report_fault(input string what, input int want_v, input int got_v);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want_v, got_v);
    endtask

    // ------------------------------------------------------------------
    // monitor: register writes, accepted samples and results, all taken
    // at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        morse_event_t want;
        if (!rst_n)
        begin
            sample_accepted = 1'b0;
            track_thr       = THRESH_RESET;
            track_dot       = DOT_RESET;
            track_on_run    = '0;
            track_off_run   = '0;
            track_pos       = '0;
            track_ovf       = 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_IDX_THRESH)
                    track_thr = cfg_data[9:0];
                else if (cfg_index == CFG_IDX_DOT)
                    track_dot = cfg_data[13:0];
            end

            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("%0t: unexpected event kind %0d char %0d",
                                 $time, event_kind, char_code);
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (event_kind !== want.kind)
                        report_fault("event_kind", want.kind, event_kind);
                    if (char_code !== want.code)
                        report_fault("char_code", want.code, char_code);
                    if (want.kind == EV_DOT)
                        dots_checked++;
                    else if (want.kind == EV_DASH)
                        dashes_checked++;
                    else
                        chars_checked++;
                end
            end

            sample_accepted = in_valid && !in_stall;
            if (sample_accepted)
            begin
                decode_sample(light_sample);
                samples_taken++;
            end
        end
    end

    // ------------------------------------------------------------------
    // sample driver: holds a request until taken, idles now and then
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || sample_accepted)
        begin
            if (sample_q.size() > 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT))
            begin
                in_valid     <= 1'b1;
                light_sample <= sample_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: random stalls plus the long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || (!calm && $urandom_range(99, 0) < IDLE_PCT);
    end

    // long receiver hold-off while the sender keeps offering samples,
    // so the result stage fills and in_stall has to rise
    initial
    begin
        wait (squeeze_go);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d events outstanding", pending_events.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_sample(input int v);
        sample_q.push_back(v[9:0]);
        queued_items++;
    endtask

    task automatic push_light(input int n);
        repeat (n) push_sample($urandom_range(cur_thr, 0));
    endtask

    task automatic push_dark(input int n);
        repeat (n) push_sample($urandom_range(SAMPLE_MAX, cur_thr + 1));
    endtask

    // one character as exact dot / dash lengths, closed by the given gap
    task automatic send_pattern(input string code, input int end_gap);
        for (int k = 0; k < code.len(); k++)
        begin
            push_light(code[k] == "." ? cur_dot : 2 * cur_dot);
            push_dark(k == code.len() - 1 ? end_gap : 1);
        end
    endtask

    // well-formed character with jittered symbol and gap lengths; eight
    // symbols walk off the bottom of the tree
    task automatic random_char();
        int nsym;
        nsym = ($urandom_range(9, 0) == 0) ? 8 : $urandom_range(7, 1);
        for (int k = 0; k < nsym; k++)
        begin
            if ($urandom_range(1, 0))
                push_light($urandom_range(3 * cur_dot + 2, 2 * cur_dot));
            else
                push_light($urandom_range(2 * cur_dot - 1, cur_dot));
            if (k == nsym - 1)
                push_dark($urandom_range(3 * cur_dot + 3, 2 * cur_dot));
            else
                push_dark($urandom_range(2 * cur_dot - 1, 1));
        end
    endtask

    // mostly characters, the rest raw noise, short flashes and long gaps
    task automatic random_unit();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 80)
            random_char();
        else if (pick < 90)
            repeat ($urandom_range(4, 1)) push_sample($urandom_range(SAMPLE_MAX, 0));
        else if (pick < 95)
        begin
            if (cur_dot > 1)
                push_light($urandom_range(cur_dot - 1, 1));
            push_dark(1);
        end
        else
            push_dark($urandom_range(6 * cur_dot, 1));
    endtask

    // everything sent, everything out, then the extra cycles the caller asks for
    task automatic settle_block(input int extra);
        int guard;
        guard = 0;
        while (sample_q.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_events.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic set_threshold(input int thr);
        write_reg(CFG_IDX_THRESH, CFG_DATA_W'(thr));
        cur_thr = thr;
    endtask

    task automatic set_dot(input int dot);
        write_reg(CFG_IDX_DOT, CFG_DATA_W'(dot));
        cur_dot = dot;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int dot_choices [RANDOM_PHASES];
        int phase_start;
        dot_choices = '{1, 2, 3, 5, 7};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: threshold edge and a dot of exactly the default
        // length; the walk stays on E and is finished below
        push_sample(10);
        push_light(399);
        push_sample(11);
        settle_block(SETTLE_CYCLES);

        // shortest dot, only a zero sample counts as light
        set_threshold(0);
        set_dot(1);
        send_pattern(".", 2);         // second dot after the pending E: I
        send_pattern("-", 2);
        send_pattern("...", 2);
        send_pattern("..--", 2);      // empty duplicate slot under U
        send_pattern(".-.-", 2);      // empty duplicate slot under R
        send_pattern("--..--", 2);    // comma, deep in the tree
        send_pattern("------", 2);    // last node, holds no character
        send_pattern(".......", 2);   // walks off the tree
        push_dark(12);                // long gap with nothing pending
        settle_block(SETTLE_CYCLES);

        // unused index, then a threshold write with stray upper bits:
        // every sample is light now and nothing comes out
        write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom_range(16383, 0)));
        write_reg(CFG_IDX_THRESH, {4'hF, 10'h3FF});
        cur_thr = SAMPLE_MAX;
        push_sample(SAMPLE_MAX);
        push_sample(0);
        push_sample(512);
        repeat (8) push_sample($urandom_range(SAMPLE_MAX, 0));
        settle_block(SETTLE_CYCLES);

        // zero dot length: every dark sample is a dash, the tree overflows
        // and the gap can never be met
        set_threshold(500);
        set_dot(0);
        push_dark(8);
        push_light(3);
        push_dark(1);
        settle_block(SETTLE_CYCLES);

        // back to a real dot length: the overflowed walk yields char 0
        set_dot(1);
        push_light(1);
        push_dark(5);
        settle_block(SETTLE_CYCLES);

        // longest dot length: a short flash and a short gap stay silent
        calm = 1'b1;
        set_threshold(SAMPLE_MAX - 1);
        set_dot(16383);
        push_light(5);
        push_dark(3);
        settle_block(SETTLE_CYCLES);
        calm = 1'b0;

        // random phases over several settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_threshold(p == 0 ? 0 : $urandom_range(SAMPLE_MAX - 1, 0));
            set_dot(dot_choices[p]);
            phase_start = queued_items;
            while (queued_items - phase_start < PHASE_SAMPLES)
                random_unit();
            if (p == 0)
                squeeze_go = 1'b1;
            calm = (p == 2);
            settle_block(SETTLE_CYCLES);
            calm = 1'b0;
        end

        settle_block(8);
        if (pending_events.size() != 0)
        begin
            $display("%0d expected events never came out", pending_events.size());
            fault_count += pending_events.size();
        end

        $display("run covered %0d samples and %0d register writes", samples_taken, reg_writes);
        $display("events checked: %0d dots, %0d dashes, %0d characters, %0d faults",
                 dots_checked, dashes_checked, chars_checked, fault_count);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/mlpd_pkg.sv
sv/mlpd_cfg_regs.sv
sv/mlpd_decoder.sv
sv/morse_light_pulse_decoder.sv
verif/tb_top.sv
